// File: src/qslerp_pkg.sv
package qslerp_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int IBITS        = 30;
    localparam int CORDIC_STEPS = 16;
    localparam int DATA_W       = 16;
    localparam int THR_W        = 15;
    localparam int THR_RESET    = 16376;

    // Q30 angle / CORDIC datapath width
    localparam int ANG_W  = 34;
    // square root: 61-bit radicand, 31-bit root
    localparam int SQ_W   = 61;
    localparam int ROOT_W = 31;
    // divider quotient bits and weight width (+-2^33)
    localparam int QB     = 35;
    localparam int W_W    = 35;
    localparam int DIV_LAT = QB + 2;

    localparam logic [ANG_W-1:0] GAIN_INV = ANG_W'(652032874);

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
        30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
        30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
        30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
        30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
        30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008,
        30'h00000004, 30'h00000002, 30'h00000001, 30'h00000000
    };

    // per-item data carried alongside the arithmetic units
    typedef struct packed {
        logic [3:0][DATA_W-1:0] a;
        logic [3:0][DATA_W:0]   b;     // possibly negated, 17 bits
        logic [FRAC_BITS:0]     t;     // clamped blend
        logic [FRAC_BITS:0]     d;     // clamped dot, Q(FRAC_BITS)
        logic [ROOT_W-1:0]      s30;   // sin(theta), Q30
        logic                   lin;
    } t_side;

endpackage

// File: src/qslerp_in_if.sv
interface qslerp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] qa_x;
    logic signed [15:0] qa_y;
    logic signed [15:0] qa_z;
    logic signed [15:0] qa_w;
    logic signed [15:0] qb_x;
    logic signed [15:0] qb_y;
    logic signed [15:0] qb_z;
    logic signed [15:0] qb_w;
    logic signed [15:0] blend;

    modport source (output valid, qa_x, qa_y, qa_z, qa_w, qb_x, qb_y, qb_z, qb_w, blend,
                    input ready);
    modport sink   (input valid, qa_x, qa_y, qa_z, qa_w, qb_x, qb_y, qb_z, qb_w, blend,
                    output ready);
endinterface

// File: src/qslerp_out_if.sv
interface qslerp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] res_x;
    logic signed [15:0] res_y;
    logic signed [15:0] res_z;
    logic signed [15:0] res_w;
    logic               linear_path;

    modport source (output valid, res_x, res_y, res_z, res_w, linear_path, input ready);
    modport sink   (input valid, res_x, res_y, res_z, res_w, linear_path, output ready);
endinterface

// File: src/qslerp_cfg_if.sv
interface qslerp_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] close_threshold;

    modport source (output valid, close_threshold, input ready);
    modport sink   (input valid, close_threshold, output ready);
endinterface

// File: src/qslerp_delay.sv
module qslerp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];
endmodule

// File: src/qslerp_isqrt.sv
module qslerp_isqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [qslerp_pkg::SQ_W-1:0]    i_v,
    output logic [qslerp_pkg::ROOT_W-1:0]  o_root
);
    localparam int N = qslerp_pkg::ROOT_W;
    localparam int W = qslerp_pkg::SQ_W + 1;

    logic [W-1:0] r_rem  [N];
    logic [W-1:0] r_root [N];

    // one result bit per stage, trial bit 4^(N-1-g)
    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [W-1:0] rem_in, root_in, trial, n_rem, n_root;
        localparam logic [W-1:0] BITV = W'(1) << (2 * (N - 1 - g));

        if (g == 0) begin : g_first
            assign rem_in  = W'(i_v);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        always_comb begin
            trial = root_in + BITV;
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = (root_in >> 1) + BITV;
            end else begin
                n_rem  = rem_in;
                n_root = root_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    assign o_root = r_root[N-1][N-1:0];
endmodule

// File: src/qslerp_cordic.sv
module qslerp_cordic #(
    parameter int STEPS  = qslerp_pkg::CORDIC_STEPS,
    parameter bit VECTOR = 1'b0
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [qslerp_pkg::ANG_W-1:0]  i_x,
    input  logic signed [qslerp_pkg::ANG_W-1:0]  i_y,
    input  logic signed [qslerp_pkg::ANG_W-1:0]  i_z,
    output logic signed [qslerp_pkg::ANG_W-1:0]  o_y,
    output logic signed [qslerp_pkg::ANG_W-1:0]  o_z
);
    localparam int AW = qslerp_pkg::ANG_W;

    logic signed [AW-1:0] r_x [STEPS];
    logic signed [AW-1:0] r_y [STEPS];
    logic signed [AW-1:0] r_z [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        logic signed [AW-1:0] x_in, y_in, z_in, dx, dy, n_x, n_y, n_z;
        logic                 up;
        localparam logic signed [AW-1:0] ATAN =
            $signed({{(AW-30){1'b0}}, qslerp_pkg::ATAN_TAB[g]});

        if (g == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
        end else begin : g_next
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
        end

        always_comb begin
            dx = y_in >>> g;
            dy = x_in >>> g;
            // vectoring drives y to zero, rotation drives z to zero
            up = VECTOR ? !y_in[AW-1] : !z_in[AW-1];
            if (VECTOR == up) begin
                n_x = x_in + dx;
                n_y = y_in - dy;
            end else begin
                n_x = x_in - dx;
                n_y = y_in + dy;
            end
            n_z = (VECTOR == up) ? z_in + ATAN : z_in - ATAN;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= n_x;
                r_y[g] <= n_y;
                r_z[g] <= n_z;
            end
        end
    end

    assign o_y = r_y[STEPS-1];
    assign o_z = r_z[STEPS-1];
endmodule

// File: src/qslerp_div.sv
module qslerp_div (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [qslerp_pkg::ANG_W-1:0]  i_num,
    input  logic [qslerp_pkg::ROOT_W-1:0]        i_den,
    output logic signed [qslerp_pkg::W_W-1:0]    o_w
);
    localparam int QB   = qslerp_pkg::QB;
    localparam int AW   = qslerp_pkg::ANG_W;
    localparam int DW   = qslerp_pkg::ROOT_W;
    localparam int RW   = DW + QB;
    localparam int WW   = qslerp_pkg::W_W;
    localparam int OVSH = QB - qslerp_pkg::IBITS;
    localparam logic [QB-1:0] LIMIT = QB'(1) << (WW - 2);

    // front stage: magnitude, sign, quotient overflow
    logic [AW-1:0] mag;
    logic [RW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [DW-1:0] r_den [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];
    logic signed [WW-1:0] r_w;

    assign mag = i_num[AW-1] ? AW'(-i_num) : AW'(i_num);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(mag) << qslerp_pkg::IBITS;
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_num[AW-1];
            r_ovf[0] <= (RW'(mag) >= (RW'(i_den) << OVSH));
        end
    end

    // restoring steps, quotient bit QB-1-g
    for (genvar g = 0; g < QB; g++) begin : g_step
        logic [RW-1:0] dsh;
        logic          take;

        assign dsh  = RW'(r_den[g]) << (QB - 1 - g);
        assign take = r_rem[g] >= dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= take ? r_rem[g] - dsh : r_rem[g];
                r_q[g+1]   <= r_q[g] | (take ? QB'(1) << (QB - 1 - g) : '0);
                r_den[g+1] <= r_den[g];
                r_neg[g+1] <= r_neg[g];
                r_ovf[g+1] <= r_ovf[g];
            end
        end
    end

    logic [QB-1:0] qsat;
    assign qsat = (r_ovf[QB] || r_q[QB] > LIMIT) ? LIMIT : r_q[QB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= r_neg[QB] ? -$signed(WW'(qsat)) : $signed(WW'(qsat));
        end
    end

    assign o_w = r_w;
endmodule

// File: src/quaternion_slerp_top.sv
// Throughput: one transaction per cycle; the whole pipeline advances together and
//   holds while a result sits unaccepted in the output register.
// Reset (i_rst_n, synchronous, active low): clears all valid bits and loads
//   close_threshold with 16376; payload registers keep their contents.
module quaternion_slerp_top #(
    parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qslerp_in_if.sink     i_in,
    qslerp_out_if.source  o_out,
    qslerp_cfg_if.sink    i_cfg
);
    localparam int F    = qslerp_pkg::FRAC_BITS;
    localparam int IB   = qslerp_pkg::IBITS;
    localparam int DW   = qslerp_pkg::DATA_W;
    localparam int AW   = qslerp_pkg::ANG_W;
    localparam int WW   = qslerp_pkg::W_W;
    localparam int RTW  = qslerp_pkg::ROOT_W;
    localparam int SW   = $bits(qslerp_pkg::t_side);
    // front end 4, sqrt 31, vectoring, angle 1, rotation, divider, products 1, output 1
    localparam int LAT  = 4 + RTW + CORDIC_STEPS + 1 + CORDIC_STEPS
                        + qslerp_pkg::DIV_LAT + 2;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    function automatic logic signed [DW-1:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767)       return 16'sh7FFF;
        else if (v < -32'sd32768) return 16'sh8000;
        else                      return v[DW-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Flow control: a single enable for every stage. The output register
    // is the last stage; a bubble there lets the pipe advance.
    // ---------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en          = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // configuration: the threshold register, always writable
    logic [qslerp_pkg::THR_W-1:0] r_thr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qslerp_pkg::THR_W'(qslerp_pkg::THR_RESET);
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.close_threshold;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: the four a*b products, blend clamped to [0, one]
    // ---------------------------------------------------------------
    logic signed [DW-1:0]   in_a [4];
    logic signed [DW-1:0]   in_b [4];
    logic signed [2*DW-1:0] r1_prod [4];
    logic signed [DW-1:0]   r1_a [4];
    logic signed [DW-1:0]   r1_b [4];
    logic [F:0]             r1_t;

    assign in_a = '{i_in.qa_x, i_in.qa_y, i_in.qa_z, i_in.qa_w};
    assign in_b = '{i_in.qb_x, i_in.qb_y, i_in.qb_z, i_in.qb_w};

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r1_prod[k] <= in_a[k] * in_b[k];
                r1_a[k]    <= in_a[k];
                r1_b[k]    <= in_b[k];
            end
            if (i_in.blend[DW-1]) begin
                r1_t <= '0;
            end else if ($signed(i_in.blend) > $signed({1'b0, ONE})) begin
                r1_t <= ONE;
            end else begin
                r1_t <= i_in.blend[F:0];
            end
        end
    end

    // Stage 2: full-precision dot product
    logic signed [2*DW+1:0] r2_dot;
    logic signed [DW-1:0]   r2_a [4];
    logic signed [DW-1:0]   r2_b [4];
    logic [F:0]             r2_t;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dot <= (2*DW+2)'(r1_prod[0]) + (2*DW+2)'(r1_prod[1])
                    + (2*DW+2)'(r1_prod[2]) + (2*DW+2)'(r1_prod[3]);
            r2_a <= r1_a;
            r2_b <= r1_b;
            r2_t <= r1_t;
        end
    end

    // Stage 3: shortest-arc flip, threshold compare, dot clamped to one
    logic [2*DW+1:0] absdot;
    logic [2*DW+1:0] thr_ext;
    logic [2*DW+1:0] d_raw;
    logic [F:0]      r3_d;
    logic            r3_lin;
    logic [F:0]      r3_t;
    logic signed [DW-1:0] r3_a [4];
    logic signed [DW:0]   r3_b [4];

    assign absdot  = r2_dot[2*DW+1] ? (2*DW+2)'(-r2_dot) : (2*DW+2)'(r2_dot);
    assign thr_ext = (2*DW+2)'(r_thr) << F;
    assign d_raw   = absdot >> F;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_lin <= absdot > thr_ext;
            r3_d   <= (d_raw > (2*DW+2)'(ONE)) ? ONE : d_raw[F:0];
            r3_t   <= r2_t;
            r3_a   <= r2_a;
            for (int k = 0; k < 4; k++) begin
                r3_b[k] <= r2_dot[2*DW+1] ? -(DW+1)'(r2_b[k]) : (DW+1)'(r2_b[k]);
            end
        end
    end

    // Stage 4: radicand 2^60 - d30^2, written as (one^2 - d^2) << (60 - 2F)
    logic [2*F+1:0]                 dsq;
    logic [2*F:0]                   rad_hi;
    logic [qslerp_pkg::SQ_W-1:0]    r4_v;
    qslerp_pkg::t_side              r4_side;

    assign dsq    = (2*F+2)'(r3_d) * (2*F+2)'(r3_d);
    assign rad_hi = (2*F+1)'(((2*F+2)'(1) << (2*F)) - dsq);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_v <= qslerp_pkg::SQ_W'(rad_hi) << (2*IB - 2*F);
            for (int k = 0; k < 4; k++) begin
                r4_side.a[k] <= r3_a[k];
                r4_side.b[k] <= r3_b[k];
            end
            r4_side.t   <= r3_t;
            r4_side.d   <= r3_d;
            r4_side.s30 <= '0;
            r4_side.lin <= r3_lin;
        end
    end

    // ---------------------------------------------------------------
    // sin(theta) = sqrt(1 - d^2), one root bit per stage
    // ---------------------------------------------------------------
    logic [RTW-1:0]    s30;
    logic [SW-1:0]     side_q_bits;
    qslerp_pkg::t_side side_q, side_v;

    qslerp_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (r4_v),
        .o_root (s30)
    );

    qslerp_delay #(.WIDTH(SW), .DEPTH(RTW)) u_dly_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r4_side),
        .o_q   (side_q_bits)
    );

    // a sine below one Q(F) LSB is the degenerate case: fall back to linear
    always_comb begin
        side_q     = side_q_bits;
        side_v     = side_q;
        side_v.s30 = s30;
        side_v.lin = side_q.lin || ((s30 >> (IB - F)) == '0);
    end

    // theta = atan2(sin, d) by vectoring CORDIC
    logic signed [AW-1:0] theta, vec_y;
    logic [SW-1:0]        side_r_bits;
    qslerp_pkg::t_side    side_r;

    qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vec (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   ($signed(AW'(side_q.d) << (IB - F))),
        .i_y   ($signed(AW'(s30))),
        .i_z   ('0),
        .o_y   (vec_y),
        .o_z   (theta)
    );

    qslerp_delay #(.WIDTH(SW), .DEPTH(CORDIC_STEPS)) u_dly_vec (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (side_v),
        .o_q   (side_r_bits)
    );

    assign side_r = side_r_bits;

    // Angle stage: (1-t)*theta and t*theta, floored at F bits
    logic [F:0]               om;
    logic signed [AW+F+1:0]   prod1, prod2;
    logic signed [AW-1:0]     r6_ang1, r6_ang2;
    qslerp_pkg::t_side        r6_side;

    assign om    = ONE - side_r.t;
    assign prod1 = $signed({1'b0, om}) * theta;
    assign prod2 = $signed({1'b0, side_r.t}) * theta;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ang1 <= prod1[AW+F-1:F];
            r6_ang2 <= prod2[AW+F-1:F];
            r6_side <= side_r;
        end
    end

    // the two sines by rotation CORDIC
    logic signed [AW-1:0] sin1, sin2, rz1, rz2;
    logic [SW-1:0]        side_c_bits;
    qslerp_pkg::t_side    side_c;

    qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   ($signed(qslerp_pkg::GAIN_INV)),
        .i_y   ('0),
        .i_z   (r6_ang1),
        .o_y   (sin1),
        .o_z   (rz1)
    );

    qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   ($signed(qslerp_pkg::GAIN_INV)),
        .i_y   ('0),
        .i_z   (r6_ang2),
        .o_y   (sin2),
        .o_z   (rz2)
    );

    qslerp_delay #(.WIDTH(SW), .DEPTH(CORDIC_STEPS)) u_dly_rot (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r6_side),
        .o_q   (side_c_bits)
    );

    assign side_c = side_c_bits;

    // weights sin/sin(theta), Q30, saturated to +-8
    logic signed [WW-1:0] w1, w2;
    logic [SW-1:0]        side_d_bits;
    qslerp_pkg::t_side    side_d;

    qslerp_div u_div1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (sin1),
        .i_den (side_c.s30),
        .o_w   (w1)
    );

    qslerp_div u_div2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (sin2),
        .i_den (side_c.s30),
        .o_w   (w2)
    );

    qslerp_delay #(.WIDTH(SW), .DEPTH(qslerp_pkg::DIV_LAT)) u_dly_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (side_c),
        .o_q   (side_d_bits)
    );

    assign side_d = side_d_bits;

    // ---------------------------------------------------------------
    // Product stage: both paths' products, selection happens at the end
    // ---------------------------------------------------------------
    logic signed [DW+WW-1:0]   r7_pa [4];
    logic signed [DW+WW:0]     r7_pb [4];
    logic signed [2*DW+1:0]    r7_pl [4];
    logic signed [DW-1:0]      r7_a  [4];
    logic                      r7_lin;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r7_pa[k] <= $signed(side_d.a[k]) * w1;
                r7_pb[k] <= $signed(side_d.b[k]) * w2;
                r7_pl[k] <= $signed({1'b0, side_d.t})
                          * ($signed((DW+2)'($signed(side_d.b[k])))
                           - $signed((DW+2)'($signed(side_d.a[k]))));
                r7_a[k]  <= $signed(side_d.a[k]);
            end
            r7_lin <= side_d.lin;
        end
    end

    // Output stage: round, saturate, pick the path
    logic signed [DW+WW+2:0] sph  [4];
    logic signed [2*DW+2:0]  lrnd [4];
    logic signed [31:0]      sph_r [4];
    logic signed [31:0]      lin_r [4];
    logic signed [DW-1:0]    r_res [4];
    logic                    r_lin;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sph[k]   = (DW+WW+3)'(r7_pa[k]) + (DW+WW+3)'(r7_pb[k])
                     + ((DW+WW+3)'(1) <<< (IB - 1));
            sph_r[k] = 32'(sph[k] >>> IB);
            lrnd[k]  = (2*DW+3)'(r7_pl[k]) + ((2*DW+3)'(1) <<< (F - 1));
            lin_r[k] = 32'(lrnd[k] >>> F) + 32'(r7_a[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_res[k] <= r7_lin ? sat16(lin_r[k]) : sat16(sph_r[k]);
            end
            r_lin <= r7_lin;
        end
    end

    assign o_out.res_x       = r_res[0];
    assign o_out.res_y       = r_res[1];
    assign o_out.res_z       = r_res[2];
    assign o_out.res_w       = r_res[3];
    assign o_out.linear_path = r_lin;
endmodule
